// File: sv/map_pkg.sv
// shared types and codes for the markov access predictor
package map_pkg;

    // operation codes of an input item
    typedef enum logic {
        OP_RECORD  = 1'b0,
        OP_PREDICT = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // fixed port widths
    localparam int unsigned PORT_KEY_BITS = 64;
    localparam int unsigned PORT_IDX_BITS = 4;

    // input item
    typedef struct packed {
        t_op                       operation;
        logic [PORT_KEY_BITS-1:0]  key;
    } t_map_cmd;

    // result item
    typedef struct packed {
        t_status                   status;
        logic [PORT_KEY_BITS-1:0]  predicted_key;
        logic [PORT_IDX_BITS-1:0]  predicted_index;
    } t_map_res;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KRD,
        S_KCMP,
        S_UPD,
        S_CRD,
        S_CWR,
        S_RRD,
        S_RCMP,
        S_BRD,
        S_BOUT
    } t_state;

endpackage

// File: sv/map_ram.sv
// single write port, single registered read port memory
module map_ram
    import map_pkg::*;
#(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/markov_access_predictor.sv
// markov access predictor: sequencer, compare unit and the two tables
//
// Input: an item is transferred at a rising edge where start is high and busy
// is low. i_cmd.operation selects record (learn the transition from the last
// recorded key to this key) or predict (most frequent successor of the key).
// Output: exactly one result per item on o_res, shown for one cycle while
// o_done is high; the receiver cannot stall, so no result is ever held back.
// Busy stays high from the transfer until the cycle the result is shown, and
// the next item can be transferred in that same cycle.
// Sequence: record searches the key table, appends a new key if absent, and
// updates the counter when a previous access exists; predict searches,
// scans the key's counter row, then reads the best successor key. An absent
// key on predict, or a new key on a full table, ends after the search.
// The key search and the row scan each read entries one at a time through
// the single read port of the key memory or the counter memory; the key
// search uses an equality compare and the row scan a magnitude compare.
// After reset the counter memory is swept to zero, one entry per cycle,
// over all its entries, with busy high; the key table is not cleared.
module markov_access_predictor
    import map_pkg::*;
#(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned KEY_BITS   = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_map_cmd i_cmd,
    output logic     busy,
    output logic     o_done,
    output t_map_res o_res
);

    localparam int unsigned SW    = $clog2(CAPACITY);
    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned DEPTH = CAPACITY * CAPACITY;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned IXW   = SW + PORT_IDX_BITS;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_slot;
    logic [SW-1:0]         r_prev;
    logic                  r_prev_valid;
    logic [SW-1:0]         r_best;
    logic [COUNT_BITS-1:0] r_best_val;
    logic                  r_done;
    t_map_res              r_res;

    logic                  w_miss, w_full, w_hit, w_clr_last, w_fin;
    logic [KEY_BITS-1:0]   w_key_rdata;
    logic [COUNT_BITS-1:0] w_cnt_rdata, w_cnt_inc;
    logic [AW-1:0]         w_trans_addr, w_row_addr;
    logic [IXW-1:0]        w_slot_ext, w_best_ext;

    logic                  w_key_we;
    logic [SW-1:0]         w_key_waddr, w_key_raddr;
    logic                  w_cnt_we;
    logic [AW-1:0]         w_cnt_waddr, w_cnt_raddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;

    // status flags and the key compare unit
    assign w_miss     = (r_idx == r_count);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_hit      = (w_key_rdata == r_key);
    assign w_clr_last = (r_clr == AW'(DEPTH - 1));
    assign w_cnt_inc  = (w_cnt_rdata == {COUNT_BITS{1'b1}}) ? w_cnt_rdata
                                                             : w_cnt_rdata + COUNT_BITS'(1);
    assign w_trans_addr = AW'(AW'(r_prev) * AW'(CAPACITY)) + AW'(r_slot);
    assign w_row_addr   = AW'(AW'(r_slot) * AW'(CAPACITY)) + AW'(r_idx[SW-1:0]);
    assign w_slot_ext   = IXW'(r_slot);
    assign w_best_ext   = IXW'(r_best);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (w_clr_last) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_KRD;
            S_KRD: begin
                if (w_miss) begin
                    n_state = (r_op == OP_RECORD && !w_full) ? S_UPD : S_IDLE;
                end else begin
                    n_state = S_KCMP;
                end
            end
            S_KCMP: begin
                if (w_hit) begin
                    n_state = (r_op == OP_RECORD) ? S_UPD : S_RRD;
                end else begin
                    n_state = S_KRD;
                end
            end
            S_UPD:   n_state = r_prev_valid ? S_CRD : S_IDLE;
            S_CRD:   n_state = S_CWR;
            S_CWR:   n_state = S_IDLE;
            S_RRD:   n_state = w_miss ? S_BRD : S_RCMP;
            S_RCMP:  n_state = S_RRD;
            S_BRD:   n_state = S_BOUT;
            S_BOUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        busy        = (r_state != S_IDLE);
        w_fin       = ((r_state == S_KRD) && w_miss && !((r_op == OP_RECORD) && !w_full))
                      || ((r_state == S_UPD) && !r_prev_valid)
                      || (r_state == S_CWR) || (r_state == S_BOUT);
        w_key_we    = (r_state == S_KRD) && w_miss && (r_op == OP_RECORD) && !w_full;
        w_key_waddr = r_count[SW-1:0];
        w_key_raddr = (r_state == S_BRD || r_state == S_BOUT) ? r_best : r_idx[SW-1:0];
        w_cnt_we    = (r_state == S_CLEAR) || (r_state == S_CWR);
        w_cnt_waddr = (r_state == S_CLEAR) ? r_clr : w_trans_addr;
        w_cnt_wdata = (r_state == S_CLEAR) ? '0 : w_cnt_inc;
        w_cnt_raddr = (r_state == S_CRD || r_state == S_CWR) ? w_trans_addr : w_row_addr;
    end

    // control registers and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_count      <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: begin
                    if (start) begin
                        r_op  <= i_cmd.operation;
                        r_key <= i_cmd.key[KEY_BITS-1:0];
                        r_idx <= '0;
                    end
                end
                S_KRD: begin
                    if (w_miss) begin
                        if (r_op == OP_RECORD && !w_full) begin
                            // append the new key
                            r_slot  <= r_count[SW-1:0];
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_res.status          <= (r_op == OP_RECORD) ? ST_FULL
                                                                         : ST_NOT_FOUND;
                            r_res.predicted_key   <= '0;
                            r_res.predicted_index <= '0;
                        end
                    end
                end
                S_KCMP: begin
                    if (w_hit) begin
                        r_slot <= r_idx[SW-1:0];
                        r_idx  <= '0;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_UPD, S_CWR: begin
                    // finish a record transfer
                    if (r_state == S_CWR || !r_prev_valid) begin
                        r_prev                <= r_slot;
                        r_prev_valid          <= 1'b1;
                        r_res.status          <= ST_OK;
                        r_res.predicted_key   <= '0;
                        r_res.predicted_index <= w_slot_ext[PORT_IDX_BITS-1:0];
                    end
                end
                S_CRD, S_RRD, S_BRD: begin
                end
                S_RCMP: begin
                    // row scan, strict compare keeps the lowest slot on ties
                    if (r_idx == '0 || w_cnt_rdata > r_best_val) begin
                        r_best     <= r_idx[SW-1:0];
                        r_best_val <= w_cnt_rdata;
                    end
                    r_idx <= r_idx + CW'(1);
                end
                S_BOUT: begin
                    r_res.status          <= ST_OK;
                    r_res.predicted_key   <= PORT_KEY_BITS'(w_key_rdata);
                    r_res.predicted_index <= w_best_ext[PORT_IDX_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // key table
    map_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (r_key),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    // transition counters, row per previous slot
    map_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

endmodule
